>>> rtl/prl_pkg.sv
`timescale 1ns / 1ps

package prl_pkg;

   localparam int CAPACITY_DEFAULT = 32;

   typedef enum logic [1:0] {
      KIND_INSERT = 2'd0,
      KIND_REMOVE = 2'd1,
      KIND_SEARCH = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_FULL     = 3'd1,
      ST_EMPTY    = 3'd2,
      ST_BADPOS   = 3'd3,
      ST_NOTFOUND = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      OP_HOLD,
      OP_INSERT,
      OP_REMOVE,
      OP_ROTATE,
      OP_MATCH
   } cell_op_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [5:0]  position;
      logic [30:0] id_number;
      logic [63:0] name_head;
      logic [7:0]  name_tail;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [5:0]  entry_count;
      logic [5:0]  found_position;
      logic [63:0] found_name_head;
      logic [7:0]  found_name_tail;
   } rsp_type;

   typedef struct packed {
      logic [30:0] id_number;
      logic [63:0] name_head;
      logic [7:0]  name_tail;
   } rec_type;

   typedef struct packed {
      cell_op_type op;
      rec_type     rec;
   } cell_ctl_type;

endpackage

>>> rtl/prl_cell.sv
`timescale 1ns / 1ps

module prl_cell #(
   parameter int CAPACITY = prl_pkg::CAPACITY_DEFAULT,
   parameter int INDEX    = 0
) (
   input  logic                         clock,
   input  prl_pkg::cell_ctl_type        ctl,
   input  logic [$clog2(CAPACITY)-1:0]  slot,
   input  logic [$clog2(CAPACITY+1)-1:0] count,
   input  prl_pkg::rec_type             prev_rec,
   input  prl_pkg::rec_type             next_rec,
   input  logic                         next_match,
   output prl_pkg::rec_type             rec,
   output logic                         match
);

   localparam int IW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic [IW-1:0] IDX    = IW'(INDEX);
   localparam logic [CW-1:0] IDX_CW = CW'(INDEX);

   prl_pkg::rec_type rec_ff, rec_in;
   logic             match_ff, match_in;

   always_comb begin
      rec_in   = rec_ff;
      match_in = match_ff;
      unique case (ctl.op)
         prl_pkg::OP_HOLD: begin
         end
         prl_pkg::OP_INSERT: begin
            if (IDX > slot) begin
               rec_in = prev_rec;
            end else if (IDX == slot) begin
               rec_in = ctl.rec;
            end
         end
         prl_pkg::OP_REMOVE: begin
            if (IDX >= slot) begin
               rec_in = next_rec;
            end
         end
         prl_pkg::OP_ROTATE: begin
            rec_in   = next_rec;
            match_in = next_match;
         end
         prl_pkg::OP_MATCH: begin
            // only cells that hold a record take part in the compare
            match_in = (IDX_CW < count) && (rec_ff.id_number == ctl.rec.id_number);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rec_ff   <= rec_in;
      match_ff <= match_in;
   end

   assign rec   = rec_ff;
   assign match = match_ff;

endmodule

>>> rtl/positional_record_list_top.sv
`timescale 1ns / 1ps

// Ordered list of up to CAPACITY records (31-bit id, nine-character name).
// Request channel: an item is taken at a rising edge with start high and busy
// low. Insert and remove act on a 1-based position; search finds the first
// record with a matching id.
// Result channel: exactly one result per item, shown for one cycle with
// rsp_strobe high; the receiver cannot stall it.
// Insert, remove, an unused kind and a search of an empty list: the result
// comes in the cycle after the transfer and busy stays low, so one item per cycle.
// Search of a non-empty list: busy is high from the transfer until the scan
// ends and the result is shown. The records live in a ring of cells; the ring rotates
// one place a cycle past the head cell, which is checked for a match, and is
// back in order after CAPACITY steps.
// Reset clears the record count, the control state and the strobe; record
// contents are not cleared.
module positional_record_list_top #(
   parameter int CAPACITY = prl_pkg::CAPACITY_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  prl_pkg::req_type req_item,
   output logic             rsp_strobe,
   output prl_pkg::rsp_type rsp_item
);

   localparam int IW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int XW = (CW > 6) ? CW + 1 : 7;

   typedef enum logic {
      S_IDLE,
      S_SCAN
   } state_type;

   state_type        state_ff;
   logic [CW-1:0]    count_ff, count_in;
   logic [IW-1:0]    step_ff;
   logic             found_ff;
   logic [5:0]       fpos_ff;
   prl_pkg::rec_type frec_ff;
   logic             rsp_strobe_ff;
   prl_pkg::rsp_type rsp_ff;

   logic                  accept;
   logic                  scan_start;
   prl_pkg::status_type   status;
   prl_pkg::cell_op_type  op;
   prl_pkg::cell_ctl_type ctl;
   logic [XW-1:0]         pos_x;
   logic [XW-1:0]         cnt_x;
   logic [IW-1:0]         slot;
   logic                  found_now;
   logic [5:0]            fpos_now;
   prl_pkg::rec_type      frec_now;
   prl_pkg::rsp_type      quick_rsp;
   prl_pkg::rsp_type      scan_rsp;

   prl_pkg::rec_type      cell_rec [CAPACITY];
   logic [CAPACITY-1:0]   cell_match;

   assign busy   = (state_ff == S_SCAN);
   assign accept = start && !busy;
   assign pos_x  = XW'(req_item.position);
   assign cnt_x  = XW'(count_ff);
   assign slot   = IW'(pos_x - XW'(1));

   always_comb begin
      status     = prl_pkg::ST_OK;
      op         = prl_pkg::OP_HOLD;
      count_in   = count_ff;
      scan_start = 1'b0;
      unique case (prl_pkg::kind_type'(req_item.kind))
         prl_pkg::KIND_INSERT: begin
            priority if (count_ff == CW'(CAPACITY)) begin
               status = prl_pkg::ST_FULL;
            end else if (pos_x == '0 || pos_x > cnt_x + XW'(1)) begin
               status = prl_pkg::ST_BADPOS;
            end else begin
               op       = prl_pkg::OP_INSERT;
               count_in = count_ff + CW'(1);
            end
         end
         prl_pkg::KIND_REMOVE: begin
            priority if (count_ff == '0) begin
               status = prl_pkg::ST_EMPTY;
            end else if (pos_x == '0 || pos_x > cnt_x) begin
               status = prl_pkg::ST_BADPOS;
            end else begin
               op       = prl_pkg::OP_REMOVE;
               count_in = count_ff - CW'(1);
            end
         end
         prl_pkg::KIND_SEARCH: begin
            if (count_ff == '0) begin
               status = prl_pkg::ST_EMPTY;
            end else begin
               op         = prl_pkg::OP_MATCH;
               scan_start = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      quick_rsp                 = '0;
      quick_rsp.status          = status;
      quick_rsp.entry_count     = 6'(count_in);
   end

   // the head cell holds original record step_ff during the scan
   assign found_now = found_ff || cell_match[0];
   assign fpos_now  = found_ff ? fpos_ff : 6'(step_ff) + 6'd1;
   assign frec_now  = found_ff ? frec_ff : cell_rec[0];

   always_comb begin
      scan_rsp             = '0;
      scan_rsp.entry_count = 6'(count_ff);
      if (found_now) begin
         scan_rsp.status          = prl_pkg::ST_OK;
         scan_rsp.found_position  = fpos_now;
         scan_rsp.found_name_head = frec_now.name_head;
         scan_rsp.found_name_tail = frec_now.name_tail;
      end else begin
         scan_rsp.status = prl_pkg::ST_NOTFOUND;
      end
   end

   always_comb begin
      ctl.rec.id_number = req_item.id_number;
      ctl.rec.name_head = req_item.name_head;
      ctl.rec.name_tail = req_item.name_tail;
      if (busy) begin
         ctl.op = prl_pkg::OP_ROTATE;
      end else if (accept) begin
         ctl.op = op;
      end else begin
         ctl.op = prl_pkg::OP_HOLD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         found_ff      <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               rsp_strobe_ff <= accept && !scan_start;
               rsp_ff        <= quick_rsp;
               if (accept) begin
                  count_ff <= count_in;
               end
               if (accept && scan_start) begin
                  state_ff <= S_SCAN;
                  step_ff  <= '0;
                  found_ff <= 1'b0;
               end
            end
            S_SCAN: begin
               step_ff  <= step_ff + IW'(1);
               found_ff <= found_now;
               fpos_ff  <= fpos_now;
               frec_ff  <= frec_now;
               if (step_ff == IW'(CAPACITY - 1)) begin
                  state_ff      <= S_IDLE;
                  rsp_strobe_ff <= 1'b1;
                  rsp_ff        <= scan_rsp;
               end else begin
                  rsp_strobe_ff <= 1'b0;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      prl_cell #(
         .CAPACITY (CAPACITY),
         .INDEX    (i)
      ) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .slot       (slot),
         .count      (count_ff),
         .prev_rec   (cell_rec[(i + CAPACITY - 1) % CAPACITY]),
         .next_rec   (cell_rec[(i + 1) % CAPACITY]),
         .next_match (cell_match[(i + 1) % CAPACITY]),
         .rec        (cell_rec[i]),
         .match      (cell_match[i])
      );
   end

endmodule

>>> rtl/prl_checker.sv
`timescale 1ns / 1ps

module prl_checker #(
   parameter int CAPACITY = prl_pkg::CAPACITY_DEFAULT
) (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_strobe,
   input prl_pkg::rsp_type rsp_item
);

   // a transfer either answers next cycle or starts a scan
   a_transfer_answered: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (rsp_strobe || busy))
      else $error("transfer neither answered nor scanning");

   a_scan_ends_in_result: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_strobe)
      else $error("scan ended without a result");

   a_no_result_while_busy: assert property (@(posedge clock) disable iff (reset)
      busy |-> !rsp_strobe)
      else $error("result during scan");

   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (int'(rsp_item.entry_count) <= CAPACITY))
      else $error("entry count above capacity");

   a_search_kind_only_found: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_item.found_position != 6'd0) |-> (rsp_item.status == prl_pkg::ST_OK))
      else $error("found position with a failing status");

endmodule

bind positional_record_list_top prl_checker #(
   .CAPACITY (CAPACITY)
) u_prl_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_item   (rsp_item)
);

>>> verif/prl_list_checker.sv
`timescale 1ns / 1ps

module prl_list_checker #(
   parameter int CAPACITY = prl_pkg::CAPACITY_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             busy,
   input  prl_pkg::req_type req_item,
   input  logic             rsp_strobe,
   input  prl_pkg::rsp_type rsp_item,
   output int               fail_count,
   output int               pending,
   output int               checked_count,
   output int               hit_count,
   output int               full_count
);
   import prl_pkg::*;

   rec_type list_rec [CAPACITY];
   int      list_fill;
   rsp_type awaited_rsp [$];
   rsp_type want;
   int      errors;
   int      checked;
   int      hits;
   int      fulls;

   initial begin
      list_fill     = 0;
      errors        = 0;
      checked       = 0;
      hits          = 0;
      fulls         = 0;
      fail_count    = 0;
      pending       = 0;
      checked_count = 0;
      hit_count     = 0;
      full_count    = 0;
   end

   // applies one item to the shadow list and returns the result it should give
   function automatic rsp_type apply_list_op(input req_type r);
      rsp_type res;
      int      p;
      int      k;
      logic    found;
      res        = '0;
      res.status = ST_OK;
      p          = r.position;
      found      = 1'b0;
      case (r.kind)
         KIND_INSERT: begin
            if (list_fill >= CAPACITY) begin
               res.status = ST_FULL;
            end else if (p == 0 || p > list_fill + 1) begin
               res.status = ST_BADPOS;
            end else begin
               for (k = list_fill; k >= p; k--) list_rec[k] = list_rec[k - 1];
               list_rec[p - 1] = {r.id_number, r.name_head, r.name_tail};
               list_fill++;
            end
         end
         KIND_REMOVE: begin
            if (list_fill == 0) begin
               res.status = ST_EMPTY;
            end else if (p == 0 || p > list_fill) begin
               res.status = ST_BADPOS;
            end else begin
               for (k = p - 1; k + 1 < list_fill; k++) list_rec[k] = list_rec[k + 1];
               list_fill--;
            end
         end
         KIND_SEARCH: begin
            if (list_fill == 0) begin
               res.status = ST_EMPTY;
            end else begin
               res.status = ST_NOTFOUND;
               for (k = 0; k < list_fill; k++) begin
                  if (!found && list_rec[k].id_number == r.id_number) begin
                     found               = 1'b1;
                     res.status          = ST_OK;
                     res.found_position  = 6'(k + 1);
                     res.found_name_head = list_rec[k].name_head;
                     res.found_name_tail = list_rec[k].name_tail;
                  end
               end
            end
         end
         default: ;
      endcase
      res.entry_count = 6'(list_fill);
      return res;
   endfunction

   task automatic log_mismatch(input string what, input rsp_type exp_r, input rsp_type got);
      errors++;
      if (errors <= 10)
         $display("%0t mismatch, %s: want st=%0d cnt=%0d pos=%0d head=%h tail=%h | got st=%0d cnt=%0d pos=%0d head=%h tail=%h",
                  $time, what, exp_r.status, exp_r.entry_count, exp_r.found_position,
                  exp_r.found_name_head, exp_r.found_name_tail, got.status, got.entry_count,
                  got.found_position, got.found_name_head, got.found_name_tail);
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         // a result belongs to an earlier transfer, so compare before predicting
         if (rsp_strobe) begin
            if (awaited_rsp.size() == 0) begin
               log_mismatch("result with none expected", '0, rsp_item);
            end else begin
               want = awaited_rsp.pop_front();
               checked++;
               if (want.status == ST_OK && want.found_position != 0) hits++;
               if (want.status == ST_FULL) fulls++;
               if (rsp_item.status !== want.status ||
                   rsp_item.entry_count !== want.entry_count ||
                   rsp_item.found_position !== want.found_position ||
                   rsp_item.found_name_head !== want.found_name_head ||
                   rsp_item.found_name_tail !== want.found_name_tail)
                  log_mismatch("field differs", want, rsp_item);
            end
         end
         if (start && !busy) awaited_rsp.push_back(apply_list_op(req_item));
      end
      fail_count    <= errors;
      pending       <= awaited_rsp.size();
      checked_count <= checked;
      hit_count     <= hits;
      full_count    <= fulls;
   end

endmodule

>>> verif/positional_record_list_top_tb.sv
`timescale 1ns / 1ps

module positional_record_list_top_tb;
   import prl_pkg::*;

   localparam int         CAP          = CAPACITY_DEFAULT;
   localparam int         RANDOM_ITEMS = 830;
   localparam int         CYCLE_LIMIT  = 400000;
   localparam logic [1:0] KIND_UNUSED  = 2'd3;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_item;
   logic    rsp_strobe;
   rsp_type rsp_item;

   int fail_count;
   int pending;
   int checked_count;
   int hit_count;
   int full_count;

   int cycle_count;
   int list_fill;
   int max_fill;
   int kind_seen [4];
   bit idle_on;
   int phase;
   int roll;
   int ins_pct;
   int rem_pct;
   int pos;
   logic [1:0] kind;

   positional_record_list_top #(.CAPACITY(CAP)) u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   prl_list_checker #(.CAPACITY(CAP)) u_checker (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_item      (req_item),
      .rsp_strobe    (rsp_strobe),
      .rsp_item      (rsp_item),
      .fail_count    (fail_count),
      .pending       (pending),
      .checked_count (checked_count),
      .hit_count     (hit_count),
      .full_count    (full_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial cycle_count = 0;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
         $display("positional_record_list_top_tb: FAIL");
         $finish;
      end
   end

   // one transfer: optional gap with start low, then hold start until taken
   task automatic issue(input logic [1:0] k, input int p, input logic [30:0] idv,
                        input logic [63:0] head, input logic [7:0] tail);
      req_type item;
      int      gap;
      item.kind      = k;
      item.position  = 6'(p);
      item.id_number = idv;
      item.name_head = head;
      item.name_tail = tail;
      gap = idle_on ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_item <= item;
      @(posedge clock);
      while (busy) @(posedge clock);
      kind_seen[k]++;
      // rough fill tracking, to steer positions toward valid ones and to record the peak fill
      if (k == KIND_INSERT && list_fill < CAP && p >= 1 && p <= list_fill + 1)
         list_fill++;
      else if (k == KIND_REMOVE && list_fill > 0 && p >= 1 && p <= list_fill)
         list_fill--;
      if (list_fill > max_fill) max_fill = list_fill;
   endtask

   // small id pool so searches hit and duplicates appear
   function automatic logic [30:0] pick_id();
      int r;
      r = $urandom_range(0, 9);
      if (r < 7) return 31'($urandom_range(0, 11));
      if (r == 7) return 31'h7FFF_FFFF;
      return 31'($urandom);
   endfunction

   function automatic logic [63:0] pick_head();
      int r;
      r = $urandom_range(0, 15);
      if (r == 0) return 64'h0;
      if (r == 1) return '1;
      return {$urandom, $urandom};
   endfunction

   initial begin
      reset     = 1'b1;
      start     = 1'b0;
      req_item  = '0;
      list_fill = 0;
      max_fill  = 0;
      idle_on   = 1'b1;
      foreach (kind_seen[i]) kind_seen[i] = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: empty list, bad positions, head/middle/tail, first match, unused kind
      issue(KIND_SEARCH, 1, 31'd0, 64'h0, 8'h00);
      issue(KIND_REMOVE, 1, 31'd0, 64'h0, 8'h00);
      issue(KIND_INSERT, 0, 31'd1, 64'h1111, 8'h11);
      issue(KIND_INSERT, 2, 31'd1, 64'h2222, 8'h22);
      issue(KIND_INSERT, 1, 31'h7FFF_FFFF, '1, 8'hFF);
      issue(KIND_INSERT, 1, 31'd0, 64'h0, 8'h00);
      issue(KIND_INSERT, 3, 31'd5, 64'h4142_4344_4546_4748, 8'h49);
      issue(KIND_INSERT, 2, 31'd5, 64'h6162_6364_6566_6768, 8'h00);
      issue(KIND_SEARCH, 0, 31'd5, 64'h0, 8'h00);
      issue(KIND_SEARCH, 63, 31'h7FFF_FFFF, 64'h0, 8'h00);
      issue(KIND_SEARCH, 1, 31'd0, 64'h0, 8'h00);
      issue(KIND_SEARCH, 1, 31'd9, 64'h0, 8'h00);
      issue(KIND_UNUSED, 63, 31'h7FFF_FFFF, '1, 8'hFF);
      issue(KIND_REMOVE, 0, 31'd0, 64'h0, 8'h00);
      issue(KIND_REMOVE, 5, 31'd0, 64'h0, 8'h00);
      issue(KIND_INSERT, 63, 31'd7, 64'h0, 8'h00);
      issue(KIND_INSERT, 5, 31'd8, 64'h8888, 8'h88);
      issue(KIND_REMOVE, 2, 31'd0, 64'h0, 8'h00);
      issue(KIND_REMOVE, 4, 31'd0, 64'h0, 8'h00);
      issue(KIND_REMOVE, 1, 31'd0, 64'h0, 8'h00);
      issue(KIND_SEARCH, 1, 31'd5, 64'h0, 8'h00);
      issue(KIND_REMOVE, 2, 31'd0, 64'h0, 8'h00);
      issue(KIND_REMOVE, 1, 31'd0, 64'h0, 8'h00);
      issue(KIND_SEARCH, 1, 31'd5, 64'h0, 8'h00);

      // random: phases that grow, shrink or churn the list
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 40 == 0) begin
            phase   = $urandom_range(0, 2);
            idle_on = ($urandom_range(0, 3) != 0);
         end
         ins_pct = (phase == 0) ? 60 : (phase == 1) ? 15 : 35;
         rem_pct = (phase == 0) ? 15 : (phase == 1) ? 60 : 35;
         roll    = $urandom_range(0, 99);
         if (roll < ins_pct) kind = KIND_INSERT;
         else if (roll < ins_pct + rem_pct) kind = KIND_REMOVE;
         else if (roll < 96) kind = KIND_SEARCH;
         else kind = KIND_UNUSED;
         if ($urandom_range(0, 9) == 0 || kind == KIND_SEARCH || kind == KIND_UNUSED)
            pos = $urandom_range(0, 63);
         else if (kind == KIND_INSERT)
            pos = $urandom_range(1, list_fill + 1);
         else
            pos = $urandom_range(1, (list_fill > 0) ? list_fill : 1);
         issue(kind, pos, pick_id(), pick_head(), 8'($urandom_range(0, 255)));
      end
      start <= 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (CAP + 4) @(posedge clock);

      $display("sent %0d inserts, %0d removes, %0d searches, %0d unused-kind items; fill peaked at %0d of %0d",
               kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], max_fill, CAP);
      $display("compared %0d results, %0d search hits, %0d inserts refused as full, %0d failures",
               checked_count, hit_count, full_count, fail_count);
      if (fail_count == 0) begin
         $display("positional_record_list_top_tb: PASS");
      end else begin
         $display("positional_record_list_top_tb: FAIL");
      end
      $finish;
   end

endmodule
